// ===== sv/mde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mde_pkg;

  localparam int DEPTH_DEF  = 32;
  localparam int RESULT_CAP = 32;

  // sequence numbers
  localparam logic [1:0] SEQ_STACK = 2'd0;
  localparam logic [1:0] SEQ_BAD   = 2'd3;

  // commands
  localparam logic [3:0] CMD_PUSH_F = 4'd0;
  localparam logic [3:0] CMD_PUSH_B = 4'd1;
  localparam logic [3:0] CMD_POP_F  = 4'd2;
  localparam logic [3:0] CMD_POP_B  = 4'd3;
  localparam logic [3:0] CMD_PEEK_F = 4'd4;
  localparam logic [3:0] CMD_PEEK_B = 4'd5;
  localparam logic [3:0] CMD_SIZE   = 4'd6;
  localparam logic [3:0] CMD_CLEAR  = 4'd7;
  localparam logic [3:0] CMD_REV    = 4'd8;
  localparam logic [3:0] CMD_ROT    = 4'd9;
  localparam logic [3:0] CMD_FIND   = 4'd10;
  localparam logic [3:0] CMD_MIN    = 4'd11;
  localparam logic [3:0] CMD_MAX    = 4'd12;
  localparam logic [3:0] CMD_DUP    = 4'd13;
  localparam logic [3:0] CMD_MV_CNT = 4'd14;
  localparam logic [3:0] CMD_MV_RNG = 4'd15;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_BADARG   = 3'd4;

  typedef struct packed {
    logic [3:0]         cmd;
    logic [1:0]         container;
    logic [1:0]         other_container;
    logic signed [31:0] item_value;
    logic [7:0]         amount;
    logic               direction;
    logic [4:0]         left_index;
    logic [4:0]         right_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic [5:0]         position;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_RDRES,
    S_DONE,
    S_MOD,
    S_GATH_RD,
    S_GATH_WR,
    S_SCAT_RD,
    S_SCAT_WR,
    S_SCAN_RD,
    S_SCAN_CK,
    S_MV_RD,
    S_MV_WR,
    S_CMP_RD,
    S_CMP_WR,
    S_INS_RD,
    S_INS_WR
  } state_t;

endpackage

`default_nettype wire

// ===== sv/mde_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mde_ram #(
  parameter int WORDS = 96,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/mde_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mde_ctrl #(
  parameter int DEPTH = mde_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire mde_pkg::in_item_t in_data,
  output mde_pkg::emit_t        emit,
  input  wire logic             emit_rdy
);
  import mde_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(3 * DEPTH);

  state_t state_r, state_nxt;

  logic [3:0]    cmd_r, cmd_nxt;
  logic [1:0]    c_r, c_nxt;
  logic [1:0]    d_r, d_nxt;
  logic [31:0]   v_r, v_nxt;
  logic [7:0]    amt_r, amt_nxt;
  logic          dir_r, dir_nxt;
  logic [4:0]    lo_r, lo_nxt;
  logic [4:0]    hi_r, hi_nxt;
  logic [IW-1:0] fp_r [3];
  logic [IW-1:0] fp_nxt [3];
  logic [CW-1:0] cnt_r [3];
  logic [CW-1:0] cnt_nxt [3];
  logic [CW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] off_r, off_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [7:0]    rem_r, rem_nxt;
  logic [2:0]    sh_r, sh_nxt;

  // memory ports
  logic          m_we, m_re;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [31:0]   m_wdata, m_rdata;
  logic          s_we, s_re;
  logic [IW-1:0] s_waddr, s_raddr;
  logic [31:0]   s_wdata, s_rdata;

  mde_ram #(.WORDS(3 * DEPTH), .AW(AW)) u_main (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  mde_ram #(.WORDS(DEPTH), .AW(IW)) u_scratch (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  function automatic logic [AW-1:0] slot_f(input logic [1:0] cc, input logic [IW-1:0] fpv,
                                           input logic [CW-1:0] idx);
    logic [CW:0]   sum;
    logic [AW-1:0] base;
    begin
      sum = (CW+1)'(fpv) + (CW+1)'(idx);
      if (sum >= (CW+1)'(DEPTH)) begin
        sum = sum - (CW+1)'(DEPTH);
      end
      case (cc)
        2'd1:    base = AW'(DEPTH);
        2'd2:    base = AW'(2 * DEPTH);
        default: base = '0;
      endcase
      return base + AW'(sum);
    end
  endfunction

  function automatic logic [IW-1:0] fp_dec(input logic [IW-1:0] f);
    begin
      return (f == '0) ? IW'(DEPTH - 1) : f - 1'b1;
    end
  endfunction

  function automatic logic [IW-1:0] fp_inc(input logic [IW-1:0] f);
    begin
      return (f == IW'(DEPTH - 1)) ? '0 : f + 1'b1;
    end
  endfunction

  logic [1:0]    cs, ds;
  logic [CW-1:0] nc, nd;
  logic [IW-1:0] fpc, fpd;
  logic [AW-1:0] ins_addr;
  logic [15:0]   room_d;
  logic [5:0]    rng_k;
  logic [15:0]   div_sh;
  logic [7:0]    rem_new;

  always_comb begin
    cs  = (c_r == SEQ_BAD) ? 2'd2 : c_r;
    ds  = (d_r == SEQ_BAD) ? 2'd2 : d_r;
    nc  = cnt_r[cs];
    nd  = cnt_r[ds];
    fpc = fp_r[cs];
    fpd = fp_r[ds];
    room_d = 16'(DEPTH) - 16'(nd);
    rng_k  = 6'(hi_r) - 6'(lo_r) + 6'd1;
    div_sh = 16'(nc) << sh_r;
    rem_new = (16'(rem_r) >= div_sh) ? rem_r - 8'(div_sh) : rem_r;
    if (ds == SEQ_STACK) begin
      ins_addr = slot_f(ds, fp_dec(fpd), '0);
    end else begin
      ins_addr = slot_f(ds, fpd, nd);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;  c_nxt = c_r;  d_nxt = d_r;  v_nxt = v_r;
    amt_nxt = amt_r;  dir_nxt = dir_r;  lo_nxt = lo_r;  hi_nxt = hi_r;
    fp_nxt  = fp_r;
    cnt_nxt = cnt_r;
    i_nxt = i_r;  j_nxt = j_r;  len_nxt = len_r;  off_nxt = off_r;
    st_nxt = st_r;  val_nxt = val_r;  pos_nxt = pos_r;
    rem_nxt = rem_r;  sh_nxt = sh_r;
    m_we = 1'b0;  m_waddr = '0;  m_wdata = '0;  m_re = 1'b0;  m_raddr = '0;
    s_we = 1'b0;  s_waddr = '0;  s_wdata = '0;  s_re = 1'b0;  s_raddr = '0;
    in_ready = 1'b0;
    emit = '0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt = in_data.cmd;
          c_nxt   = in_data.container;
          d_nxt   = in_data.other_container;
          v_nxt   = in_data.item_value;
          amt_nxt = in_data.amount;
          dir_nxt = in_data.direction;
          lo_nxt  = in_data.left_index;
          hi_nxt  = in_data.right_index;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        st_nxt  = ST_OK;
        val_nxt = '0;
        pos_nxt = '0;
        i_nxt   = '0;
        off_nxt = '0;
        j_nxt   = '0;
        state_nxt = S_DONE;
        if (c_r == SEQ_BAD || (cmd_r >= CMD_DUP && d_r == SEQ_BAD)) begin
          st_nxt = ST_BADARG;
        end else begin
          case (cmd_r)
            CMD_PUSH_F, CMD_PUSH_B: begin
              if (16'(nc) >= 16'(DEPTH)) begin
                st_nxt = ST_FULL;
              end else begin
                m_we    = 1'b1;
                m_wdata = v_r;
                if (cmd_r == CMD_PUSH_F) begin
                  m_waddr    = slot_f(cs, fp_dec(fpc), '0);
                  fp_nxt[cs] = fp_dec(fpc);
                end else begin
                  m_waddr = slot_f(cs, fpc, nc);
                end
                cnt_nxt[cs] = nc + 1'b1;
              end
            end
            CMD_POP_F, CMD_POP_B, CMD_PEEK_F, CMD_PEEK_B: begin
              if (nc == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                m_re = 1'b1;
                if (cmd_r == CMD_POP_F || cmd_r == CMD_PEEK_F) begin
                  m_raddr = slot_f(cs, fpc, '0);
                end else begin
                  m_raddr = slot_f(cs, fpc, nc - 1'b1);
                end
                if (cmd_r == CMD_POP_F) begin
                  fp_nxt[cs] = fp_inc(fpc);
                end
                if (cmd_r == CMD_POP_F || cmd_r == CMD_POP_B) begin
                  cnt_nxt[cs] = nc - 1'b1;
                end
                state_nxt = S_RDRES;
              end
            end
            CMD_SIZE: begin
              pos_nxt = 6'(nc);
            end
            CMD_CLEAR: begin
              cnt_nxt[cs] = '0;
              fp_nxt[cs]  = '0;
            end
            CMD_REV, CMD_DUP: begin
              len_nxt   = nc;
              state_nxt = S_GATH_RD;
            end
            CMD_ROT: begin
              if (nc > CW'(1)) begin
                rem_nxt   = amt_r;
                sh_nxt    = 3'd7;
                state_nxt = S_MOD;
              end
            end
            CMD_FIND, CMD_MIN, CMD_MAX: begin
              if (nc == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            CMD_MV_CNT: begin
              if (16'(amt_r) > 16'(nc) || 16'(amt_r) > 16'(RESULT_CAP)) begin
                st_nxt = ST_BADARG;
              end else if (d_r != c_r && 16'(amt_r) > room_d) begin
                st_nxt = ST_FULL;
              end else if (amt_r != '0) begin
                state_nxt = S_MV_RD;
              end
            end
            CMD_MV_RNG: begin
              if (lo_r > hi_r || 16'(hi_r) >= 16'(nc)) begin
                st_nxt = ST_BADARG;
              end else if (d_r != c_r && 16'(rng_k) > room_d) begin
                st_nxt = ST_FULL;
              end else begin
                len_nxt   = CW'(rng_k);
                off_nxt   = CW'(lo_r);
                state_nxt = S_GATH_RD;
              end
            end
            default: begin
              st_nxt = ST_BADARG;
            end
          endcase
        end
      end

      S_RDRES: begin
        val_nxt   = m_rdata;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        emit.valid = 1'b1;
        emit.item  = '{status: st_r, result_value: val_r, position: pos_r, last: 1'b1};
        if (emit_rdy) begin
          state_nxt = S_IDLE;
        end
      end

      // restoring remainder of amount by length, one bit per cycle
      S_MOD: begin
        rem_nxt = rem_new;
        sh_nxt  = sh_r - 1'b1;
        if (sh_r == '0) begin
          if (rem_new == '0) begin
            state_nxt = S_DONE;
          end else begin
            j_nxt     = dir_r ? IW'(nc - CW'(rem_new)) : IW'(rem_new);
            len_nxt   = nc;
            state_nxt = S_GATH_RD;
          end
        end
      end

      S_GATH_RD: begin
        if (i_r == len_r) begin
          if (cmd_r == CMD_MV_RNG) begin
            i_nxt     = CW'(lo_r);
            state_nxt = S_CMP_RD;
          end else begin
            i_nxt = '0;
            if (cmd_r == CMD_REV) begin
              j_nxt = IW'(len_r - 1'b1);
            end else if (cmd_r == CMD_DUP) begin
              j_nxt       = '0;
              fp_nxt[ds]  = '0;
              cnt_nxt[ds] = len_r;
            end
            state_nxt = S_SCAT_RD;
          end
        end else begin
          m_re      = 1'b1;
          m_raddr   = slot_f(cs, fpc, i_r + off_r);
          state_nxt = S_GATH_WR;
        end
      end

      S_GATH_WR: begin
        s_we      = 1'b1;
        s_waddr   = IW'(i_r);
        s_wdata   = m_rdata;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_GATH_RD;
      end

      S_SCAT_RD: begin
        if (i_r == len_r) begin
          state_nxt = S_DONE;
        end else begin
          s_re      = 1'b1;
          s_raddr   = j_r;
          state_nxt = S_SCAT_WR;
        end
      end

      S_SCAT_WR: begin
        m_we    = 1'b1;
        m_wdata = s_rdata;
        if (cmd_r == CMD_DUP) begin
          m_waddr = slot_f(ds, fpd, i_r);
        end else begin
          m_waddr = slot_f(cs, fpc, i_r);
        end
        i_nxt = i_r + 1'b1;
        if (cmd_r == CMD_REV) begin
          j_nxt = j_r - 1'b1;
        end else if (cmd_r == CMD_ROT && CW'(j_r) == len_r - 1'b1) begin
          j_nxt = '0;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        state_nxt = S_SCAT_RD;
      end

      S_SCAN_RD: begin
        if (i_r == nc) begin
          if (cmd_r == CMD_FIND) begin
            st_nxt = ST_NOTFOUND;
          end
          state_nxt = S_DONE;
        end else begin
          m_re      = 1'b1;
          m_raddr   = slot_f(cs, fpc, i_r);
          state_nxt = S_SCAN_CK;
        end
      end

      S_SCAN_CK: begin
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SCAN_RD;
        case (cmd_r)
          CMD_FIND: begin
            if (m_rdata == v_r) begin
              pos_nxt   = 6'(i_r);
              state_nxt = S_DONE;
            end
          end
          CMD_MIN: begin
            if (i_r == '0 || $signed(m_rdata) < $signed(val_r)) begin
              val_nxt = m_rdata;
            end
          end
          default: begin
            if (i_r == '0 || $signed(m_rdata) > $signed(val_r)) begin
              val_nxt = m_rdata;
            end
          end
        endcase
      end

      // take the front value, then place it in the destination
      S_MV_RD: begin
        m_re        = 1'b1;
        m_raddr     = slot_f(cs, fpc, '0);
        fp_nxt[cs]  = fp_inc(fpc);
        cnt_nxt[cs] = nc - 1'b1;
        state_nxt   = S_MV_WR;
      end

      S_MV_WR: begin
        emit.valid = 1'b1;
        emit.item  = '{status: ST_OK, result_value: m_rdata, position: 6'd0,
                       last: (16'(i_r) + 16'd1 == 16'(amt_r))};
        if (emit_rdy) begin
          m_we        = 1'b1;
          m_waddr     = ins_addr;
          m_wdata     = m_rdata;
          cnt_nxt[ds] = nd + 1'b1;
          if (ds == SEQ_STACK) begin
            fp_nxt[ds] = fp_dec(fpd);
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = (16'(i_r) + 16'd1 == 16'(amt_r)) ? S_IDLE : S_MV_RD;
        end
      end

      // close the gap left by the cut range
      S_CMP_RD: begin
        if ((CW+1)'(i_r) + (CW+1)'(len_r) >= (CW+1)'(nc)) begin
          cnt_nxt[cs] = nc - len_r;
          i_nxt       = '0;
          state_nxt   = S_INS_RD;
        end else begin
          m_re      = 1'b1;
          m_raddr   = slot_f(cs, fpc, i_r + len_r);
          state_nxt = S_CMP_WR;
        end
      end

      S_CMP_WR: begin
        m_we      = 1'b1;
        m_waddr   = slot_f(cs, fpc, i_r);
        m_wdata   = m_rdata;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_CMP_RD;
      end

      S_INS_RD: begin
        s_re      = 1'b1;
        s_raddr   = IW'(i_r);
        state_nxt = S_INS_WR;
      end

      S_INS_WR: begin
        emit.valid = 1'b1;
        emit.item  = '{status: ST_OK, result_value: s_rdata, position: 6'd0,
                       last: (i_r + 1'b1 == len_r)};
        if (emit_rdy) begin
          m_we        = 1'b1;
          m_waddr     = ins_addr;
          m_wdata     = s_rdata;
          cnt_nxt[ds] = nd + 1'b1;
          if (ds == SEQ_STACK) begin
            fp_nxt[ds] = fp_dec(fpd);
          end
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_r + 1'b1 == len_r) ? S_IDLE : S_INS_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int q = 0; q < 3; q++) begin
        fp_r[q]  <= '0;
        cnt_r[q] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fp_r    <= fp_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  c_r <= c_nxt;  d_r <= d_nxt;  v_r <= v_nxt;
    amt_r <= amt_nxt;  dir_r <= dir_nxt;  lo_r <= lo_nxt;  hi_r <= hi_nxt;
    i_r <= i_nxt;  j_r <= j_nxt;  len_r <= len_nxt;  off_r <= off_nxt;
    st_r <= st_nxt;  val_r <= val_nxt;  pos_r <= pos_nxt;
    rem_r <= rem_nxt;  sh_r <= sh_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/multi_deque_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready  | in_data  (mde_pkg::in_item_t)
// out_    | output    | out_valid / out_ready| out_data (mde_pkg::out_item_t)
//
// One command at a time; element store is a single-port-write, registered-read
// memory, so every element step is a read, then a consume/write.
// Rotate first runs remainder steps; range moves add the gather and compaction.
// Reset clears the state, pointers, counts and output valid only; a stalled
// result beat holds the engine.

module multi_deque_engine #(
  parameter int DEPTH = mde_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mde_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mde_pkg::out_item_t     out_data
);
  import mde_pkg::*;

  emit_t     emit;
  logic      emit_rdy;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  mde_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .emit     (emit),
    .emit_rdy (emit_rdy)
  );

  // output register: take a new beat when empty or being drained
  assign emit_rdy = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit.valid && emit_rdy) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit.item;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import mde_pkg::*;

  localparam int NSEQ       = 3;
  localparam int SEQ_DEPTH  = 32;
  localparam int DRAIN_CYC  = 400;
  localparam int MAX_REPORT = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  multi_deque_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Shadow copy of the three sequences: ring store, front index, length.
  logic [31:0] shadow_mem [NSEQ][SEQ_DEPTH];
  int          shadow_front [NSEQ];
  int          shadow_len [NSEQ];

  in_item_t  cmd_backlog[$];
  out_item_t expected_beats[$];
  int        mismatches = 0;
  int        beats_sent = 0;
  int        beats_seen = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  // Clock: 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int ring_slot(int c, int i);
    return (shadow_front[c] + i) % SEQ_DEPTH;
  endfunction

  function automatic void push_beat(logic [2:0] st, logic [31:0] val, int pos, bit lst);
    out_item_t b;
    b.status       = st;
    b.result_value = val;
    b.position     = pos[5:0];
    b.last         = lst;
    expected_beats.insert(expected_beats.size(), b);
  endfunction

  // Append one command to the stimulus backlog.
  function automatic void queue_cmd(in_item_t it);
    cmd_backlog.insert(cmd_backlog.size(), it);
  endfunction

  function automatic void put_front(int c, logic [31:0] v);
    shadow_front[c] = (shadow_front[c] + SEQ_DEPTH - 1) % SEQ_DEPTH;
    shadow_mem[c][ring_slot(c, 0)] = v;
    shadow_len[c]++;
  endfunction

  function automatic void put_back(int c, logic [31:0] v);
    shadow_mem[c][ring_slot(c, shadow_len[c])] = v;
    shadow_len[c]++;
  endfunction

  function automatic logic [31:0] take_front(int c);
    logic [31:0] v;
    v = shadow_mem[c][ring_slot(c, 0)];
    shadow_front[c] = (shadow_front[c] + 1) % SEQ_DEPTH;
    shadow_len[c]--;
    return v;
  endfunction

  // Transfers land at the front of the stack and at the back of the others.
  function automatic void move_in(int d, logic [31:0] v);
    if (d == SEQ_STACK) put_front(d, v);
    else put_back(d, v);
  endfunction

  // Work out the result beats of one accepted command and update the shadow.
  function automatic void predict_command(in_item_t it);
    logic [31:0] tmp [SEQ_DEPTH];
    logic [31:0] best, a;
    int c, d, n, k, amt, lo, hi;
    c   = it.container;
    d   = it.other_container;
    amt = it.amount;
    lo  = it.left_index;
    hi  = it.right_index;
    if (it.container == SEQ_BAD ||
        (it.cmd >= CMD_DUP && it.other_container == SEQ_BAD)) begin
      push_beat(ST_BADARG, 0, 0, 1);
      return;
    end
    n = shadow_len[c];
    case (it.cmd)
      CMD_PUSH_F, CMD_PUSH_B: begin
        if (n >= SEQ_DEPTH) begin
          push_beat(ST_FULL, 0, 0, 1);
        end else begin
          if (it.cmd == CMD_PUSH_F) put_front(c, it.item_value);
          else put_back(c, it.item_value);
          push_beat(ST_OK, 0, 0, 1);
        end
      end
      CMD_POP_F, CMD_POP_B, CMD_PEEK_F, CMD_PEEK_B: begin
        if (n == 0) begin
          push_beat(ST_EMPTY, 0, 0, 1);
        end else begin
          if (it.cmd == CMD_POP_F) best = take_front(c);
          else if (it.cmd == CMD_POP_B) begin
            best = shadow_mem[c][ring_slot(c, n - 1)];
            shadow_len[c]--;
          end else if (it.cmd == CMD_PEEK_F) best = shadow_mem[c][ring_slot(c, 0)];
          else best = shadow_mem[c][ring_slot(c, n - 1)];
          push_beat(ST_OK, best, 0, 1);
        end
      end
      CMD_SIZE: push_beat(ST_OK, 0, n, 1);
      CMD_CLEAR: begin
        shadow_len[c]   = 0;
        shadow_front[c] = 0;
        push_beat(ST_OK, 0, 0, 1);
      end
      CMD_REV: begin
        for (int i = 0; i < n / 2; i++) begin
          a = shadow_mem[c][ring_slot(c, i)];
          shadow_mem[c][ring_slot(c, i)] = shadow_mem[c][ring_slot(c, n - 1 - i)];
          shadow_mem[c][ring_slot(c, n - 1 - i)] = a;
        end
        push_beat(ST_OK, 0, 0, 1);
      end
      CMD_ROT: begin
        if (n > 1) begin
          k = amt % n;
          if (k != 0) begin
            if (it.direction) k = n - k;
            for (int i = 0; i < n; i++) tmp[i] = shadow_mem[c][ring_slot(c, (i + k) % n)];
            for (int i = 0; i < n; i++) shadow_mem[c][ring_slot(c, i)] = tmp[i];
          end
        end
        push_beat(ST_OK, 0, 0, 1);
      end
      CMD_FIND: begin
        if (n == 0) begin
          push_beat(ST_EMPTY, 0, 0, 1);
        end else begin
          k = -1;
          for (int i = 0; i < n; i++)
            if (k < 0 && shadow_mem[c][ring_slot(c, i)] == it.item_value) k = i;
          if (k >= 0) push_beat(ST_OK, 0, k, 1);
          else push_beat(ST_NOTFOUND, 0, 0, 1);
        end
      end
      CMD_MIN, CMD_MAX: begin
        if (n == 0) begin
          push_beat(ST_EMPTY, 0, 0, 1);
        end else begin
          best = shadow_mem[c][ring_slot(c, 0)];
          for (int i = 1; i < n; i++) begin
            a = shadow_mem[c][ring_slot(c, i)];
            if (it.cmd == CMD_MIN ? ($signed(a) < $signed(best))
                                  : ($signed(best) < $signed(a))) best = a;
          end
          push_beat(ST_OK, best, 0, 1);
        end
      end
      CMD_DUP: begin
        for (int i = 0; i < n; i++) tmp[i] = shadow_mem[c][ring_slot(c, i)];
        shadow_front[d] = 0;
        shadow_len[d]   = 0;
        for (int i = 0; i < n; i++) put_back(d, tmp[i]);
        push_beat(ST_OK, 0, 0, 1);
      end
      CMD_MV_CNT: begin
        if (amt > n || amt > RESULT_CAP) push_beat(ST_BADARG, 0, 0, 1);
        else if (d != c && amt > SEQ_DEPTH - shadow_len[d]) push_beat(ST_FULL, 0, 0, 1);
        else if (amt == 0) push_beat(ST_OK, 0, 0, 1);
        else begin
          for (int i = 0; i < amt; i++) begin
            best = take_front(c);
            move_in(d, best);
            push_beat(ST_OK, best, 0, i + 1 == amt);
          end
        end
      end
      default: begin
        k = hi - lo + 1;
        if (lo > hi || hi >= n) push_beat(ST_BADARG, 0, 0, 1);
        else if (d != c && k > SEQ_DEPTH - shadow_len[d]) push_beat(ST_FULL, 0, 0, 1);
        else begin
          // Cut the range out first, close the gap, then insert value by value.
          for (int i = 0; i < k; i++) tmp[i] = shadow_mem[c][ring_slot(c, lo + i)];
          for (int i = lo; i + k < n; i++)
            shadow_mem[c][ring_slot(c, i)] = shadow_mem[c][ring_slot(c, i + k)];
          shadow_len[c] = n - k;
          for (int i = 0; i < k; i++) begin
            move_in(d, tmp[i]);
            push_beat(ST_OK, tmp[i], 0, i + 1 == k);
          end
        end
      end
    endcase
  endfunction

  function automatic in_item_t mk_cmd(logic [3:0] op, logic [1:0] c, logic [1:0] d,
                                      logic [31:0] v, logic [7:0] amt, logic dir,
                                      logic [4:0] lo, logic [4:0] hi);
    in_item_t it;
    it.cmd = op; it.container = c; it.other_container = d; it.item_value = v;
    it.amount = amt; it.direction = dir; it.left_index = lo; it.right_index = hi;
    return it;
  endfunction

  // Mostly values from a small pool so that find hits, with extremes and noise.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom;
      default: return $urandom_range(0, 7) - 3;
    endcase
  endfunction

  // No idle gaps in every third stretch of 40 beats, so that long bursts occur too.
  function automatic int draw_gap(int count);
    if ((count / 40) % 3 == 2) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Driver: hold a beat until accepted, then advance after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_command(in_data);
        beats_sent <= beats_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (cmd_backlog.size() != 0) begin
          in_data  <= cmd_backlog[0];
          cmd_backlog.delete(0);
          in_valid <= 1'b1;
          send_gap <= draw_gap(beats_sent);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen <= beats_seen + 1;
        if (expected_beats.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_REPORT)
            $display("unexpected beat: status %0d value %0d pos %0d last %0b",
                     out_data.status, out_data.result_value, out_data.position,
                     out_data.last);
        end else begin
          out_item_t exp_b;
          exp_b = expected_beats[0];
          expected_beats.delete(0);
          if (out_data !== exp_b) begin
            mismatches <= mismatches + 1;
            if (mismatches < MAX_REPORT)
              $display("mismatch: exp st %0d val %0d pos %0d last %0b, got st %0d val %0d pos %0d last %0b",
                       exp_b.status, exp_b.result_value, exp_b.position, exp_b.last,
                       out_data.status, out_data.result_value, out_data.position,
                       out_data.last);
          end
        end
      end
      if (recv_gap != 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid && out_ready) recv_gap <= draw_gap(beats_seen);
      end
    end
  end

  // Stimulus: directed corner cases, then weighted random traffic.
  initial begin
    int          c, d, op, choice;
    logic [31:0] v;
    for (int s = 0; s < NSEQ; s++) begin
      shadow_front[s] = 0;
      shadow_len[s]   = 0;
    end
    // Empty sequences, bad sequence numbers, field extremes.
    queue_cmd(mk_cmd(CMD_POP_F, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PEEK_B, 1, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_FIND, 2, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MIN, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_B, SEQ_BAD, 0, 5, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_DUP, 0, SEQ_BAD, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_F, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_F, 0, 0, 32'h7fff_ffff, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_B, 0, 0, 32'hffff_ffff, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_B, 1, 0, 7, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_B, 1, 0, -3, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_PUSH_F, 1, 0, 9, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_SIZE, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MAX, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MIN, 0, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_FIND, 0, 0, 32'hffff_ffff, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_FIND, 1, 0, 123, 0, 0, 0, 0));
    // Rotate by a multiple of the length, then right by the widest distance.
    queue_cmd(mk_cmd(CMD_ROT, 0, 0, 0, 3, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_ROT, 0, 0, 0, 8'hff, 1, 0, 0));
    queue_cmd(mk_cmd(CMD_REV, 1, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_DUP, 1, 2, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MV_CNT, 2, 0, 0, 0, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MV_CNT, 2, 0, 0, 8'hff, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MV_CNT, 2, 0, 0, 2, 0, 0, 0));
    queue_cmd(mk_cmd(CMD_MV_RNG, 0, 1, 0, 0, 0, 5'd31, 5'd31));
    queue_cmd(mk_cmd(CMD_MV_RNG, 0, 1, 0, 0, 0, 1, 3));
    queue_cmd(mk_cmd(CMD_CLEAR, 1, 0, 0, 0, 0, 0, 0));

    while (cmd_backlog.size() < 350) begin
      c      = ($urandom_range(0, 19) == 0) ? SEQ_BAD : $urandom_range(0, 2);
      d      = ($urandom_range(0, 19) == 0) ? SEQ_BAD : $urandom_range(0, 2);
      choice = $urandom_range(0, 99);
      if (choice < 4) begin
        // Push depth plus one values, each to a random sequence, toward the full case.
        for (int i = 0; i < SEQ_DEPTH + 1; i++)
          queue_cmd(mk_cmd($urandom_range(0, 1), $urandom_range(0, 2), 0,
                           pick_value(), 0, 0, 0, 0));
      end else if (choice < 40) begin
        queue_cmd(mk_cmd($urandom_range(0, 1), c, d, pick_value(),
                         $urandom, $urandom, $urandom, $urandom));
      end else begin
        op = $urandom_range(2, 15);
        if (op == CMD_CLEAR && $urandom_range(0, 3) != 0) op = CMD_SIZE;
        v  = pick_value();
        queue_cmd(mk_cmd(op, c, d, v,
                         ($urandom_range(0, 7) == 0) ? $urandom
                                                     : $urandom_range(0, 6),
                         $urandom,
                         ($urandom_range(0, 7) == 0) ? $urandom
                                                     : $urandom_range(0, 4),
                         ($urandom_range(0, 7) == 0) ? $urandom
                                                     : $urandom_range(0, 8)));
      end
    end

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything accepted, every beat back, then a quiet spell.
    do @(negedge clk); while (cmd_backlog.size() != 0 || in_valid);
    do @(negedge clk); while (expected_beats.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== multi_deque_engine.f =====
sv/mde_pkg.sv
sv/mde_ram.sv
sv/mde_ctrl.sv
sv/multi_deque_engine.sv
dv/tb.sv
